[design/lhg_pkg.sv]
// Shared types, constants and the exp lookup table for the landmark heatmap generator.
`timescale 1ns / 1ps
package lhg_pkg;

  localparam int MAX_POINTS      = 63;
  localparam int SLOT_W          = 6;
  localparam int COORD_W         = 16;
  localparam int VAL_W           = 16;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  // t is Q.22 and the table covers t in [0, 16), so index = t >> (26 - IDX_W), rounded
  localparam int K_SHIFT         = 26 - IDX_W;
  localparam int DX_W            = 19;   // cell center minus point, signed Q.4
  localparam int SQ_W            = 36;   // squared distance, Q.8
  localparam int DC_W            = 27;   // squared distance clamped to 2^26
  localparam int T_W             = DC_W + 16;
  localparam int TQ_W            = 26;   // t below 16.0 in Q.22
  localparam int E_W             = 31;   // table entry, Q1.30 up to 1.0
  localparam int DIFF_W          = 27;
  localparam int PROD_W          = DIFF_W + E_W + 1;
  localparam int MAX_W           = 15;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CELL = 1'b1;

  localparam logic [1:0] VIS_OCCLUDED = 2'd1;
  localparam logic [1:0] VIS_VISIBLE  = 2'd2;

  localparam logic [2:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [2:0] CFG_DOWNSAMPLE  = 3'd1;
  localparam logic [2:0] CFG_INV_SIGMA   = 3'd2;
  localparam logic [2:0] CFG_MAP_KIND    = 3'd3;

  localparam logic MAP_LAPLACIAN = 1'b0;
  localparam logic MAP_GAUSSIAN  = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         vis;
  } point_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              ok;
    logic [SLOT_W-1:0] ch;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_BG
  } seq_state_t;

  typedef logic [E_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // exp(-16*k/DEPTH) in Q1.30: Taylor sum for one step, then repeated products
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        acc;
    logic signed [63:0] sum;
    x    = 64'h4_0000_0000 / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    sum  = $signed(term);
    term = ((term * x) >> 30) / 64'd1;  sum = sum - $signed(term);
    term = ((term * x) >> 30) / 64'd2;  sum = sum + $signed(term);
    term = ((term * x) >> 30) / 64'd3;  sum = sum - $signed(term);
    term = ((term * x) >> 30) / 64'd4;  sum = sum + $signed(term);
    term = ((term * x) >> 30) / 64'd5;  sum = sum - $signed(term);
    term = ((term * x) >> 30) / 64'd6;  sum = sum + $signed(term);
    term = ((term * x) >> 30) / 64'd7;  sum = sum - $signed(term);
    term = ((term * x) >> 30) / 64'd8;  sum = sum + $signed(term);
    term = ((term * x) >> 30) / 64'd9;  sum = sum - $signed(term);
    term = ((term * x) >> 30) / 64'd10; sum = sum + $signed(term);
    term = ((term * x) >> 30) / 64'd11; sum = sum - $signed(term);
    term = ((term * x) >> 30) / 64'd12; sum = sum + $signed(term);
    acc    = 64'd1 << 30;
    tab[0] = E_W'(acc);
    for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
      acc    = (acc * $unsigned(sum) + (64'd1 << 29)) >> 30;
      tab[k] = E_W'(acc);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[design/lhg_cell.sv]
// One point cell of the storage ring: load by slot or take the neighbor's point.
`timescale 1ns / 1ps
module lhg_cell
  import lhg_pkg::*;
(
  input  logic   clk,
  input  logic   wr,
  input  point_t wr_pt,
  input  logic   shift,
  input  point_t nb_pt,
  output point_t pt
);

  point_t pt_r;

  // Load a point or advance the ring by one place
  always_ff @(posedge clk) begin
    if (wr) begin
      pt_r <= wr_pt;
    end else if (shift) begin
      pt_r <= nb_pt;
    end
  end

  assign pt = pt_r;

endmodule

[design/lhg_value.sv]
// Per-point heatmap value pipeline: distance, scale, exp lookup and map shaping.
`timescale 1ns / 1ps
module lhg_value
  import lhg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  tok_t                   tok_in,
  input  point_t                 pt_in,
  input  logic signed [DX_W-1:0] cx,
  input  logic signed [DX_W-1:0] cy,
  input  logic [15:0]            inv_sigma,
  input  logic                   map_kind,
  output tok_t                   res_tok,
  output logic [VAL_W-1:0]       res_val
);

  tok_t tok1_r, tok2_r, tok3_r, tok4_r, tok5_r, tok6_r;
  logic signed [DX_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]        dxsq_r, dysq_r;
  logic [DC_W-1:0]        d2c_r;
  logic [TQ_W-1:0]        tq4_r, tq5_r;
  logic                   z4_r, z5_r, z6_r;
  logic [E_W-1:0]         e_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [16:0]            gq_r;

  tok_t                     tok_ok;
  logic signed [2*DX_W-1:0] pxx, pyy;
  logic [SQ_W-1:0]          d2;
  logic [T_W-1:0]           t_full;
  logic [TQ_W:0]            k_sum;
  logic [IDX_W:0]           k_full;
  logic signed [DIFF_W-1:0] diff;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        mag_rnd;
  logic [PROD_W-38:0]       q;
  logic [31:0]              g_sum;

  // Tag the request with whether its point is annotated
  assign tok_ok = '{valid: tok_in.valid, last: tok_in.last,
                    ok: (pt_in.vis == VIS_OCCLUDED) || (pt_in.vis == VIS_VISIBLE),
                    ch: tok_in.ch};

  assign pxx    = dx_r * dx_r;
  assign pyy    = dy_r * dy_r;
  assign d2     = dxsq_r + dysq_r;
  assign t_full = T_W'(d2c_r) * T_W'(inv_sigma);
  assign k_sum  = {1'b0, tq4_r} + (TQ_W+1)'(1 << (K_SHIFT - 1));
  assign k_full = k_sum[TQ_W:K_SHIFT];
  assign diff   = DIFF_W'(1 << 22) - $signed({1'b0, tq5_r});
  assign g_sum  = 32'(e_r) + 32'(1 << 14);

  // Advance all stages together while the output side moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
      tok3_r <= '0;
      tok4_r <= '0;
      tok5_r <= '0;
      tok6_r <= '0;
    end else if (en) begin
      tok1_r    <= tok_ok;
      tok2_r    <= tok1_r;
      tok3_r    <= tok2_r;
      tok4_r    <= tok3_r;
      tok5_r    <= tok4_r;
      tok6_r    <= tok5_r;
    end
  end

  // Payload path
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= cx - DX_W'($signed(pt_in.x));
      dy_r   <= cy - DX_W'($signed(pt_in.y));
      dxsq_r <= pxx[SQ_W-1:0];
      dysq_r <= pyy[SQ_W-1:0];
      // clamp: anything at or beyond 2^26 already gives t >= 16 unless scale is zero
      d2c_r  <= (|d2[SQ_W-1:DC_W-1]) ? DC_W'(1 << 26) : d2[DC_W-1:0];
      tq4_r  <= t_full[TQ_W-1:0];
      z4_r   <= !tok3_r.ok || (|t_full[T_W-1:TQ_W]);
      tq5_r  <= tq4_r;
      z5_r   <= z4_r || k_full[IDX_W];
      e_r    <= EXP_TAB[k_full[IDX_W-1:0]];
      z6_r   <= z5_r;
      prod_r <= diff * $signed({1'b0, e_r});
      gq_r   <= g_sum[31:15];
    end
  end

  assign mag     = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign mag_rnd = mag + PROD_W'(64'd1 << 36);
  assign q       = mag_rnd[PROD_W-1:37];

  // Shape the final value: round, apply sign, saturate
  always_comb begin
    res_val = '0;
    if (z6_r) begin
      res_val = '0;
    end else if (map_kind == MAP_GAUSSIAN) begin
      res_val = (gq_r > 17'd32767) ? 16'h7FFF : gq_r[VAL_W-1:0];
    end else if (!prod_r[PROD_W-1]) begin
      res_val = (q > 22'd32767) ? 16'h7FFF : q[VAL_W-1:0];
    end else begin
      res_val = (q > 22'd32768) ? 16'h8000 : VAL_W'(-q[VAL_W-1:0]);
    end
  end

  assign res_tok = tok6_r;

endmodule

[design/landmark_heatmap_generator.sv]
// Top level: config registers, point ring, sweep sequencer and output register.
//
//   port group  direction  handshake         payload
//   in_*        input      in_valid/in_stall req_type, point_slot, point_x/y, point_vis,
//                                            cell_col, cell_row
//   out_*       output     out_valid/out_stall channel, map_value, last_channel
//   cfg_*       input      cfg_we            cfg_index, cfg_data
//
// A load request is written into its ring cell when accepted. In a cell request the
// 63-place point ring rotates once around (one point a cycle while the output is not
// stalled) and then the background value is issued through the value pipeline.
// Reset is synchronous, active low; stored points are not cleared.
// A stalled output freezes the ring, the sequencer and the value pipeline.
`timescale 1ns / 1ps
module landmark_heatmap_generator
  import lhg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [SLOT_W-1:0]  in_point_slot,
  input  logic [COORD_W-1:0] in_point_x,
  input  logic [COORD_W-1:0] in_point_y,
  input  logic [1:0]         in_point_vis,
  input  logic [7:0]         in_cell_col,
  input  logic [7:0]         in_cell_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SLOT_W-1:0]  out_channel,
  output logic [VAL_W-1:0]   out_map_value,
  output logic               out_last_channel,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [SLOT_W-1:0] CNT_LAST = SLOT_W'(MAX_POINTS - 1);

  logic [SLOT_W-1:0] pc_r;
  logic [4:0]        ds_r;
  logic [15:0]       inv_r;
  logic              kind_r;

  seq_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] n_r;
  logic signed [DX_W-1:0] cx_r, cy_r;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_ch_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;
  logic [MAX_W-1:0]  m_r;

  logic              adv;
  logic              acc;
  logic              load_acc;
  logic              cell_acc;
  logic              rotate;
  tok_t              issue;
  point_t            wr_pt;
  point_t            ring_pt [MAX_POINTS];
  tok_t              res_tok;
  logic [VAL_W-1:0]  res_val;
  logic [12:0]       colp, rowp;
  logic [VAL_W-1:0]  bg_val;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign load_acc = acc && (in_req_type == REQ_LOAD);
  assign cell_acc = acc && (in_req_type == REQ_CELL);
  assign wr_pt    = '{x: in_point_x, y: in_point_y, vis: in_point_vis};

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= SLOT_W'(1);
      ds_r   <= 5'd8;
      inv_r  <= 16'd167;
      kind_r <= MAP_GAUSSIAN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: pc_r   <= cfg_data[SLOT_W-1:0];
        CFG_DOWNSAMPLE:  ds_r   <= cfg_data[4:0];
        CFG_INV_SIGMA:   inv_r  <= cfg_data;
        CFG_MAP_KIND:    kind_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Point ring: cell i takes from cell i+1, cell 0 feeds the pipeline
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
    localparam int NB = (i + 1) % MAX_POINTS;
    lhg_cell u_cell (
      .clk   (clk),
      .wr    (load_acc && (in_point_slot == SLOT_W'(i))),
      .wr_pt (wr_pt),
      .shift (rotate),
      .nb_pt (ring_pt[NB]),
      .pt    (ring_pt[i])
    );
  end

  // Cell center in Q.4: 8*d - 8 + 16*index*d, kept modulo 2^DX_W
  assign colp = 13'(in_cell_col) * 13'(ds_r);
  assign rowp = 13'(in_cell_row) * 13'(ds_r);

  always_ff @(posedge clk) begin
    if (cell_acc) begin
      cx_r <= DX_W'({colp, 4'b0}) + DX_W'({ds_r, 3'b0}) - DX_W'(8);
      cy_r <= DX_W'({rowp, 4'b0}) + DX_W'({ds_r, 3'b0}) - DX_W'(8);
      n_r  <= pc_r;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sweep the ring once, then issue the background request
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rotate    = 1'b0;
    issue     = '0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (cell_acc) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (adv) begin
          rotate      = 1'b1;
          issue.valid = (cnt_r < n_r);
          issue.ch    = cnt_r;
          cnt_nxt     = cnt_r + SLOT_W'(1);
          if (cnt_r == CNT_LAST) state_nxt = ST_BG;
        end
      end
      ST_BG: begin
        if (adv) begin
          issue.valid = 1'b1;
          issue.last  = 1'b1;
          issue.ch    = n_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  lhg_value u_value (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .tok_in    (issue),
    .pt_in     (ring_pt[0]),
    .cx        (cx_r),
    .cy        (cy_r),
    .inv_sigma (inv_r),
    .map_kind  (kind_r),
    .res_tok   (res_tok),
    .res_val   (res_val)
  );

  assign bg_val = (m_r == '0) ? 16'h7FFF : VAL_W'(17'd32768 - 17'(m_r));

  // Output register with running maximum for the background value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      m_r         <= '0;
    end else if (adv) begin
      out_valid_r <= res_tok.valid;
      if (res_tok.valid) begin
        if (res_tok.last) begin
          m_r <= '0;
        end else if (!res_val[VAL_W-1] && (res_val[MAX_W-1:0] > m_r)) begin
          m_r <= res_val[MAX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_tok.valid) begin
      out_ch_r   <= res_tok.ch;
      out_last_r <= res_tok.last;
      out_val_r  <= res_tok.last ? bg_val : res_val;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_ch_r;
  assign out_map_value    = out_val_r;
  assign out_last_channel = out_last_r;

  // Background leaves with the maximum already cleared for the next cell
  a_bg_clears_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> m_r == '0)
    else $error("running maximum not cleared with background");

  // Point values never exceed the tracked maximum
  a_max_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> $signed(out_val_r) <= $signed({1'b0, m_r}))
    else $error("running maximum below an emitted value");

  // Background issue only after a full ring rotation
  a_bg_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BG |-> cnt_r == SLOT_W'(MAX_POINTS))
    else $error("background issued with ring misaligned");

  // Nothing enters the pipeline while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !issue.valid && !rotate)
    else $error("request issued while idle");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the landmark heatmap generator.
`timescale 1ns / 1ps
module tb_top;
  import lhg_pkg::*;

  localparam logic [2:0] CFG_SPARE   = 3'd7;  // index with no register behind it
  localparam int         DRAIN_WAIT  = 80;    // margin for a cell sweep plus the pipeline
  localparam int         HEAT_ONE    = 32768;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    logic               kind;     // REQ_LOAD or REQ_CELL
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         vis;
    logic [7:0]         col;
    logic [7:0]         row;
  } request_t;

  typedef struct {
    row_kind_t  rk;
    logic [2:0] idx;
    logic [15:0] data;
    request_t   r;
    bit         fixed;
    int         pt_val;
    int         bg_val;
  } stim_row_t;

  typedef struct {
    logic [SLOT_W-1:0] ch;
    logic [VAL_W-1:0]  val;
    logic              last;
  } heat_out_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = 1'b0;
  logic [SLOT_W-1:0]  in_point_slot = '0;
  logic [COORD_W-1:0] in_point_x = '0;
  logic [COORD_W-1:0] in_point_y = '0;
  logic [1:0]         in_point_vis = '0;
  logic [7:0]         in_cell_col = '0;
  logic [7:0]         in_cell_row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SLOT_W-1:0]  out_channel;
  logic [VAL_W-1:0]   out_map_value;
  logic               out_last_channel;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  landmark_heatmap_generator dut (.*);

  // mirror of the block's state
  longint unsigned    exp_lut [EXP_TABLE_DEPTH];
  logic [COORD_W-1:0] pt_x [MAX_POINTS];
  logic [COORD_W-1:0] pt_y [MAX_POINTS];
  logic [1:0]         pt_vis [MAX_POINTS];
  logic [5:0]         num_points = 6'd1;
  logic [4:0]         cell_pitch = 5'd8;
  logic [15:0]        inv_sigma = 16'd167;
  logic               heat_kind = MAP_GAUSSIAN;

  heat_out_t pending_vals[$];
  int        mismatches = 0;
  bit        quiet = 0;

  // append one expected value at the tail of the queue
  function automatic void expect_val(heat_out_t v);
    pending_vals.insert(pending_vals.size(), v);
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // build exp(-16k/DEPTH) in Q1.30 by a truncated Taylor step and repeated products
  function automatic void fill_exp_lut();
    longint unsigned step, term, base;
    longint          acc;
    step = (64'd1 << 34) / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * step) >> 30) / n;
      acc  = (n % 2) ? acc - longint'(term) : acc + longint'(term);
    end
    base = longint'(acc);
    exp_lut[0] = 64'd1 << 30;
    for (int k = 1; k < EXP_TABLE_DEPTH; k++)
      exp_lut[k] = (exp_lut[k-1] * base + (64'd1 << 29)) >> 30;
  endfunction

  // heat value of one stored point at a cell center (Q.4 coordinates)
  function automatic int heat_value(int slot, longint cx, longint cy);
    longint          dx, dy;
    longint unsigned d2, t, k, e, q;
    if (pt_vis[slot] != VIS_OCCLUDED && pt_vis[slot] != VIS_VISIBLE) return 0;
    dx = cx - longint'($signed(pt_x[slot]));
    dy = cy - longint'($signed(pt_y[slot]));
    d2 = dx * dx + dy * dy;
    t  = d2 * inv_sigma;
    if (t >= (64'd16 << 22)) return 0;
    k = (t * EXP_TABLE_DEPTH + (64'd1 << 25)) >> 26;
    if (k >= EXP_TABLE_DEPTH) return 0;
    e = exp_lut[k];
    if (heat_kind == MAP_GAUSSIAN) begin
      q = (e + (64'd1 << 14)) >> 15;
      return (q > 32767) ? 32767 : int'(q);
    end
    if (t <= (64'd1 << 22)) begin
      q = (((64'd1 << 22) - t) * e + (64'd1 << 36)) >> 37;
      return (q > 32767) ? 32767 : int'(q);
    end
    q = ((t - (64'd1 << 22)) * e + (64'd1 << 36)) >> 37;
    return (q > 32768) ? -32768 : -int'(q);
  endfunction

  // update the point store or queue the expected channel values of a cell
  function automatic void predict_heat(request_t r);
    longint cx, cy, pitch;
    int     n, v, peak, bg;
    if (r.kind == REQ_LOAD) begin
      if (r.slot < MAX_POINTS) begin
        pt_x[r.slot]   = r.x;
        pt_y[r.slot]   = r.y;
        pt_vis[r.slot] = r.vis;
      end
      return;
    end
    pitch = cell_pitch;
    cx    = 8 * pitch - 8 + longint'(r.col) * 16 * pitch;
    cy    = 8 * pitch - 8 + longint'(r.row) * 16 * pitch;
    n     = (num_points > MAX_POINTS) ? MAX_POINTS : num_points;
    peak  = 0;
    for (int i = 0; i < n; i++) begin
      v = heat_value(i, cx, cy);
      if (v > peak) peak = v;
      expect_val('{SLOT_W'(i), VAL_W'(v), 1'b0});
    end
    bg = HEAT_ONE - peak;
    if (bg > 32767) bg = 32767;
    expect_val('{num_points, VAL_W'(bg), 1'b1});
  endfunction

  // hold the request until accepted, with an optional gap before it
  task automatic send_req(request_t r, bit fixed = 0, int pt_val = 0, int bg_val = 0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= r.kind;
    in_point_slot <= r.slot;
    in_point_x    <= r.x;
    in_point_y    <= r.y;
    in_point_vis  <= r.vis;
    in_cell_col   <= r.col;
    in_cell_row   <= r.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fixed && r.kind == REQ_CELL) begin
      if (num_points != 0) expect_val('{'0, VAL_W'(pt_val), 1'b0});
      expect_val('{num_points, VAL_W'(bg_val), 1'b1});
    end else begin
      predict_heat(r);
    end
  endtask

  // drain the block, then write one register
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POINT_COUNT: num_points = data[5:0];
      CFG_DOWNSAMPLE:  cell_pitch = data[4:0];
      CFG_INV_SIGMA:   inv_sigma  = data;
      CFG_MAP_KIND:    heat_kind  = data[0];
      default: ;
    endcase
  endtask

  function automatic request_t load_req(int slot, int x, int y, int vis);
    return '{REQ_LOAD, SLOT_W'(slot), COORD_W'(x), COORD_W'(y), 2'(vis), 8'd0, 8'd0};
  endfunction

  function automatic request_t cell_req(int col, int row);
    request_t r;
    r      = '{REQ_CELL, '0, '0, '0, '0, 8'(col), 8'(row)};
    r.slot = SLOT_W'($urandom);
    r.x    = COORD_W'($urandom);
    r.y    = COORD_W'($urandom);
    r.vis  = 2'($urandom);
    return r;
  endfunction

  // random point placed near a cell of the small grid, or anywhere
  function automatic request_t rand_load(int slot);
    int c, x, y;
    if ($urandom_range(0, 4) == 0)
      return load_req(slot, $urandom, $urandom, $urandom_range(0, 3));
    c = cell_pitch;
    x = 8 * c - 8 + $urandom_range(0, 7) * 16 * c + $urandom_range(0, 400) - 200;
    y = 8 * c - 8 + $urandom_range(0, 7) * 16 * c + $urandom_range(0, 400) - 200;
    return load_req(slot, x, y, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3)
                                                            : $urandom_range(1, 2));
  endfunction

  function automatic request_t rand_cell();
    if ($urandom_range(0, 9) == 0) return cell_req($urandom_range(0, 255),
                                                   $urandom_range(0, 255));
    return cell_req($urandom_range(0, 7), $urandom_range(0, 7));
  endfunction

  // random stall bursts on the result side
  initial begin
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= $urandom_range(0, 1);
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // compare each accepted value with the oldest expectation
  always @(posedge clk) begin
    heat_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected value: ch %0d val %0d last %0b",
                   out_channel, $signed(out_map_value), out_last_channel);
      end else begin
        want = pending_vals.pop_front();
        if (want.ch !== out_channel || want.val !== out_map_value ||
            want.last !== out_last_channel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("value mismatch: exp ch %0d val %0d last %0b, got ch %0d val %0d last %0b",
                     want.ch, $signed(want.val), want.last, out_channel,
                     $signed(out_map_value), out_last_channel);
        end
      end
    end
  end

  stim_row_t directed[$];

  // append one row to the directed table
  function automatic void add_row(stim_row_t s);
    directed.insert(directed.size(), s);
  endfunction

  function automatic stim_row_t req_row(request_t r, bit fixed = 0, int p = 0, int b = 0);
    return '{ROW_REQ, '0, '0, r, fixed, p, b};
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] idx, int data);
    return '{ROW_CFG, idx, 16'(data), load_req(0, 0, 0, 0), 1'b0, 0, 0};
  endfunction

  initial begin
    int phase_items;
    fill_exp_lut();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // point on the center of cell 0 saturates, unannotated or ignored gives zero
    add_row(req_row(load_req(0, 56, 56, VIS_VISIBLE)));
    add_row(req_row(cell_req(0, 0), 1, 32767, 1));
    add_row(req_row(cell_req(255, 255)));
    add_row(req_row(load_req(0, -32768, 32767, 0)));
    add_row(req_row(cell_req(0, 0), 1, 0, 32767));
    add_row(req_row(load_req(0, 32767, -32768, 3)));
    add_row(req_row(cell_req(0, 0), 1, 0, 32767));
    add_row(req_row(load_req(63, 56, 56, VIS_VISIBLE)));
    add_row(req_row(cell_req(0, 0), 1, 0, 32767));
    add_row(req_row(load_req(0, 56, 56, VIS_OCCLUDED)));
    add_row(cfg_row(CFG_MAP_KIND, MAP_LAPLACIAN));
    add_row(req_row(cell_req(0, 0), 1, 32767, 1));
    add_row(req_row(cell_req(1, 0)));
    add_row(req_row(cell_req(2, 0)));
    add_row(cfg_row(CFG_INV_SIGMA, 0));
    add_row(req_row(cell_req(255, 255), 1, 32767, 1));
    add_row(cfg_row(CFG_INV_SIGMA, 65535));
    add_row(cfg_row(CFG_MAP_KIND, MAP_GAUSSIAN));
    add_row(req_row(cell_req(0, 1)));
    add_row(cfg_row(CFG_DOWNSAMPLE, 0));
    add_row(req_row(cell_req(3, 3)));
    add_row(cfg_row(CFG_DOWNSAMPLE, 31));
    add_row(req_row(cell_req(255, 0)));
    add_row(cfg_row(CFG_POINT_COUNT, 0));
    add_row(req_row(cell_req(5, 5), 1, 0, 32767));
    add_row(cfg_row(CFG_SPARE, 16'hFFFF));
    add_row(cfg_row(CFG_POINT_COUNT, 1));
    add_row(cfg_row(CFG_INV_SIGMA, 167));
    add_row(cfg_row(CFG_DOWNSAMPLE, 8));

    foreach (directed[i]) begin
      if (directed[i].rk == ROW_CFG) write_reg(directed[i].idx, directed[i].data);
      else send_req(directed[i].r, directed[i].fixed, directed[i].pt_val, directed[i].bg_val);
    end

    // fill every slot so any point count reads written points only
    for (int s = 0; s < MAX_POINTS; s++) send_req(rand_load(s));

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_POINT_COUNT,
                16'((ph == 0) ? 63 : (ph == 1) ? 1 : $urandom_range(0, 63)));
      write_reg(CFG_DOWNSAMPLE, 16'((ph == 2) ? 16 : $urandom_range(0, 31)));
      write_reg(CFG_INV_SIGMA, 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(20, 2000)));
      write_reg(CFG_MAP_KIND, 16'($urandom_range(0, 1)));
      if (ph == 7) quiet = 1;
      phase_items = 25;
      for (int i = 0; i < phase_items; i++) begin
        if ($urandom_range(0, 9) < 3) send_req(rand_load($urandom_range(0, 63)));
        else send_req(rand_cell());
      end
    end

    in_valid <= 1'b0;
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_vals.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
